[hdl/vsbe_pkg.sv]
// Package for the voxel splat and blend engine.
// Holds operation codes and the fixed field widths and constants.
// It depends on nothing else.
package vsbe_pkg;

  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned POS_BITS    = 11;
  localparam int unsigned COLOR_BITS  = 8;
  localparam int unsigned FACTOR_BITS = 9;
  localparam int unsigned OUT_BITS    = 16;
  localparam int unsigned ALPHA_BITS  = 8;

  localparam logic [FACTOR_BITS-1:0] ALPHA_ONE = 9'd256;
  localparam logic [FACTOR_BITS-1:0] ALPHA_HALF = 9'd128;

  // Reciprocal of 255 scaled by 2^32, exact for dividends below 2^24.
  localparam logic [24:0] RECIP_255   = 25'd16843010;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [23:0] ROUND_255   = 24'd127;

  localparam logic [2:0] LAST_NEIGHBOR = 3'd7;

  typedef enum logic [OP_BITS-1:0] {
    OP_SPLAT = 3'd0,
    OP_SET   = 3'd1,
    OP_FILL  = 3'd2,
    OP_DIM   = 3'd3,
    OP_READ  = 3'd4
  } op_e;

endpackage

[hdl/vsbe_req_if.sv]
// Request channel interface of the voxel splat and blend engine.
// Depends on vsbe_pkg for field widths.
interface vsbe_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [vsbe_pkg::OP_BITS-1:0]         operation;
  logic [vsbe_pkg::POS_BITS-1:0]        pos_x;
  logic [vsbe_pkg::POS_BITS-1:0]        pos_y;
  logic [vsbe_pkg::POS_BITS-1:0]        pos_z;
  logic [vsbe_pkg::COLOR_BITS-1:0]      red_in;
  logic [vsbe_pkg::COLOR_BITS-1:0]      green_in;
  logic [vsbe_pkg::COLOR_BITS-1:0]      blue_in;
  logic [vsbe_pkg::FACTOR_BITS-1:0]     blend_factor;

  modport source (output valid, operation, pos_x, pos_y, pos_z, red_in, green_in,
                  blue_in, blend_factor, input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_z, red_in, green_in,
                blue_in, blend_factor, output ready);
endinterface

[hdl/vsbe_rsp_if.sv]
// Response channel interface of the voxel splat and blend engine.
// Depends on vsbe_pkg for field widths.
interface vsbe_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [vsbe_pkg::OUT_BITS-1:0]   red_out;
  logic [vsbe_pkg::OUT_BITS-1:0]   green_out;
  logic [vsbe_pkg::OUT_BITS-1:0]   blue_out;
  logic                            read_valid;

  modport source (output valid, red_out, green_out, blue_out, read_valid, input ready);
  modport sink (input valid, red_out, green_out, blue_out, read_valid, output ready);
endinterface

[hdl/voxel_splat_blend_engine_unit.sv]
// Top level of the voxel splat and blend engine: sequencer, colour scaling,
// weights and dim logic. Depends on vsbe_pkg, vsbe_req_if, vsbe_rsp_if,
// vsbe_store and vsbe_blend.
//
//   Channel | Dir | Handshake   | Carries
//   req_i   | in  | valid/ready | operation, position, colour, blend factor
//   rsp_o   | out | valid/ready | stored RGB of a read, read_valid flag
//
// One request is worked on at a time; each gives exactly one response.
// Set, read and unknown codes make at most one memory access; splat reads,
// weights, blends and writes back each neighbor inside the cube and skips
// each one outside it; fill and dim pass over every voxel. All of this is
// paced by the single voxel memory port pair, one access per cycle.
// After reset a clearing pass writes zero to every voxel, during which no
// request is taken.
// The response register lets a new request be taken while the previous
// response still waits; a finished request waits in its last state until the
// response register is free.
module voxel_splat_blend_engine_unit #(
  parameter int unsigned CUBE_SIDE     = 8,
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned CHANNEL_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  vsbe_req_if.sink   req_i,
  vsbe_rsp_if.source rsp_o
);

  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned NVOX  = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
  localparam int unsigned AW    = $clog2(NVOX);
  localparam int unsigned DW    = 3 * CB;
  localparam int unsigned IW    = vsbe_pkg::POS_BITS;
  localparam int unsigned EXT   = IW + F;
  localparam int unsigned P1W   = vsbe_pkg::FACTOR_BITS + F;
  localparam int unsigned P2W   = vsbe_pkg::FACTOR_BITS + 2 * F;
  localparam int unsigned WB    = vsbe_pkg::FACTOR_BITS + 3 * F;
  localparam int unsigned SS    = vsbe_pkg::ALPHA_BITS + 3 * F;
  localparam logic [AW-1:0] LAST_VOX = AW'(NVOX - 1);
  localparam logic [CB-1:0] CHAN_MAX = {CB{1'b1}};

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DISP     = 13'b0000000000100,
    S_FILL     = 13'b0000000001000,
    S_DIM      = 13'b0000000010000,
    S_DIM_TAIL = 13'b0000000100000,
    S_SP_RD    = 13'b0000001000000,
    S_SP_W2    = 13'b0000010000000,
    S_SP_W3    = 13'b0000100000000,
    S_SP_MUL   = 13'b0001000000000,
    S_SP_WR    = 13'b0010000000000,
    S_RD_WAIT  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_e;

  // Control state.
  state_e        state_q, state_d;
  logic [2:0]    n_q, n_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          dim_pend_q, dim_pend_d;
  logic          out_valid_q, out_valid_d;

  // Request payload and working registers.
  vsbe_pkg::op_e op_q;
  logic [IW-1:0] ix_q, iy_q, iz_q;
  logic [F-1:0]  fx_q, fy_q, fz_q;
  logic [CB-1:0] col_q [3];
  logic [vsbe_pkg::FACTOR_BITS-1:0] fac_q;
  logic [vsbe_pkg::FACTOR_BITS-1:0] a_q;
  logic [P1W-1:0] p1_q;
  logic [P2W-1:0] p2_q;
  logic [WB-1:0]  w_q;
  logic [AW-1:0]  nb_addr_q;
  logic [AW-1:0]  dim_addr_q;
  logic [DW-1:0]  res_rgb_q, out_rgb_q;
  logic           res_rd_q, out_rd_q;

  // Memory port signals.
  logic          mem_we, mem_re, blend_cap;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata, blend_new, col_word, dim_word;

  logic [EXT-1:0] ext_x, ext_y, ext_z;
  logic [CB-1:0]  col_in [3];
  logic [IW:0]    nx, ny, nz;
  logic           nb_in, cur_in, out_free;
  logic [AW-1:0]  nb_addr, cur_addr;

  function automatic logic [AW-1:0] addr_of(logic [IW:0] x, logic [IW:0] y, logic [IW:0] z);
    addr_of = AW'(x) * AW'(CUBE_SIDE * CUBE_SIDE) + AW'(y) * AW'(CUBE_SIDE) + AW'(z);
  endfunction

  // Lower neighbor takes ONE - f, upper neighbor takes f.
  function automatic logic [F:0] axis_w(logic [F-1:0] f, logic upper);
    axis_w = upper ? {1'b0, f} : ((F+1)'(1) << F) - {1'b0, f};
  endfunction

  function automatic logic [CB-1:0] dim_chan(logic [CB-1:0] v,
                                             logic [vsbe_pkg::FACTOR_BITS-1:0] f);
    logic [CB+9:0] prod;
    logic [CB+1:0] shifted;
    prod    = (CB+10)'(v) * (CB+10)'(f) + (CB+10)'(vsbe_pkg::ALPHA_HALF);
    shifted = prod[CB+9:vsbe_pkg::ALPHA_BITS];
    dim_chan = (shifted > (CB+2)'(CHAN_MAX)) ? CHAN_MAX : shifted[CB-1:0];
  endfunction

  // Colour scaling: round(c * CHAN_MAX / 255) via a reciprocal multiply.
  always_comb begin
    logic [7:0]  c8 [3];
    logic [23:0] num;
    logic [48:0] prod;
    c8[0] = req_i.red_in;
    c8[1] = req_i.green_in;
    c8[2] = req_i.blue_in;
    for (int c = 0; c < 3; c++) begin
      num       = 24'(c8[c]) * 24'(CHAN_MAX) + vsbe_pkg::ROUND_255;
      prod      = 49'(num) * 49'(vsbe_pkg::RECIP_255);
      col_in[c] = prod[vsbe_pkg::RECIP_SHIFT +: CB];
    end
  end

  assign ext_x = EXT'(req_i.pos_x);
  assign ext_y = EXT'(req_i.pos_y);
  assign ext_z = EXT'(req_i.pos_z);

  assign col_word = {col_q[2], col_q[1], col_q[0]};

  // Neighbor n has offsets dx = n[2], dy = n[1], dz = n[0].
  assign nx = (IW+1)'(ix_q) + (IW+1)'(n_q[2]);
  assign ny = (IW+1)'(iy_q) + (IW+1)'(n_q[1]);
  assign nz = (IW+1)'(iz_q) + (IW+1)'(n_q[0]);
  assign nb_in = (nx < (IW+1)'(CUBE_SIDE)) && (ny < (IW+1)'(CUBE_SIDE))
              && (nz < (IW+1)'(CUBE_SIDE));
  assign nb_addr = addr_of(nx, ny, nz);

  assign cur_in = (ix_q < IW'(CUBE_SIDE)) && (iy_q < IW'(CUBE_SIDE))
               && (iz_q < IW'(CUBE_SIDE));
  assign cur_addr = addr_of({1'b0, ix_q}, {1'b0, iy_q}, {1'b0, iz_q});

  for (genvar c = 0; c < 3; c++) begin : g_dim
    assign dim_word[c*CB +: CB] = dim_chan(mem_rdata[c*CB +: CB], fac_q);
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    dim_pend_d  = dim_pend_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q;
    blend_cap   = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == LAST_VOX) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (op_q)
          vsbe_pkg::OP_SPLAT: begin
            n_d     = '0;
            state_d = S_SP_RD;
          end
          vsbe_pkg::OP_SET: begin
            mem_we    = cur_in;
            mem_waddr = cur_addr;
            mem_wdata = col_word;
            state_d   = S_DONE;
          end
          vsbe_pkg::OP_FILL: begin
            cnt_d   = '0;
            state_d = S_FILL;
          end
          vsbe_pkg::OP_DIM: begin
            cnt_d      = '0;
            dim_pend_d = 1'b0;
            state_d    = S_DIM;
          end
          vsbe_pkg::OP_READ: begin
            mem_re    = cur_in;
            mem_raddr = cur_addr;
            state_d   = cur_in ? S_RD_WAIT : S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = col_word;
        if (cnt_q == LAST_VOX) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_DIM: begin
        // Read voxel cnt while writing back the voxel read in the cycle before.
        mem_re     = 1'b1;
        dim_pend_d = 1'b1;
        mem_we     = dim_pend_q;
        mem_waddr  = dim_addr_q;
        mem_wdata  = dim_word;
        if (cnt_q == LAST_VOX) begin
          state_d = S_DIM_TAIL;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_DIM_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = dim_addr_q;
        mem_wdata = dim_word;
        state_d   = S_DONE;
      end
      S_SP_RD: begin
        if (nb_in) begin
          mem_re    = 1'b1;
          mem_raddr = nb_addr;
          state_d   = S_SP_W2;
        end else if (n_q == vsbe_pkg::LAST_NEIGHBOR) begin
          state_d = S_DONE;
        end else begin
          n_d = n_q + 3'd1;
        end
      end
      S_SP_W2: begin
        state_d = S_SP_W3;
      end
      S_SP_W3: begin
        state_d = S_SP_MUL;
      end
      S_SP_MUL: begin
        blend_cap = 1'b1;
        state_d   = S_SP_WR;
      end
      S_SP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = nb_addr_q;
        mem_wdata = blend_new;
        if (n_q == vsbe_pkg::LAST_NEIGHBOR) begin
          state_d = S_DONE;
        end else begin
          n_d     = n_q + 3'd1;
          state_d = S_SP_RD;
        end
      end
      S_RD_WAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      n_q         <= '0;
      cnt_q       <= '0;
      dim_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      dim_pend_q  <= dim_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      op_q  <= vsbe_pkg::op_e'(req_i.operation);
      ix_q  <= ext_x[EXT-1:F];
      iy_q  <= ext_y[EXT-1:F];
      iz_q  <= ext_z[EXT-1:F];
      fx_q  <= ext_x[F-1:0];
      fy_q  <= ext_y[F-1:0];
      fz_q  <= ext_z[F-1:0];
      fac_q <= req_i.blend_factor;
      for (int c = 0; c < 3; c++) begin
        col_q[c] <= col_in[c];
      end
    end
    if (state_q == S_DISP) begin
      // Opacity above one is held at one.
      a_q       <= (fac_q > vsbe_pkg::ALPHA_ONE) ? vsbe_pkg::ALPHA_ONE : fac_q;
      res_rgb_q <= '0;
      res_rd_q  <= 1'b0;
    end
    if (state_q == S_SP_RD) begin
      nb_addr_q <= nb_addr;
      p1_q      <= P1W'(a_q) * P1W'(axis_w(fx_q, n_q[2]));
    end
    if (state_q == S_SP_W2) begin
      p2_q <= P2W'(p1_q) * P2W'(axis_w(fy_q, n_q[1]));
    end
    if (state_q == S_SP_W3) begin
      w_q <= WB'(p2_q) * WB'(axis_w(fz_q, n_q[0]));
    end
    if (state_q == S_DIM) begin
      dim_addr_q <= cnt_q;
    end
    if (state_q == S_RD_WAIT) begin
      res_rgb_q <= mem_rdata;
      res_rd_q  <= 1'b1;
    end
    if (state_q == S_DONE && out_free) begin
      out_rgb_q <= res_rgb_q;
      out_rd_q  <= res_rd_q;
    end
  end

  vsbe_store #(
    .DEPTH (NVOX),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  vsbe_blend #(
    .CB (CB),
    .WB (WB),
    .SS (SS)
  ) u_blend (
    .clk_i (clk_i),
    .cap_i (blend_cap),
    .old_i (mem_rdata),
    .col_i (col_word),
    .w_i   (w_q),
    .new_o (blend_new)
  );

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.red_out   = vsbe_pkg::OUT_BITS'(out_rgb_q[0*CB +: CB]);
  assign rsp_o.green_out = vsbe_pkg::OUT_BITS'(out_rgb_q[1*CB +: CB]);
  assign rsp_o.blue_out  = vsbe_pkg::OUT_BITS'(out_rgb_q[2*CB +: CB]);
  assign rsp_o.read_valid = out_rd_q;

  // A read and a write never hit the same voxel in one cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write of the same voxel in one cycle");

  // A response that is not a read carries zero channels.
  a_zero_non_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.read_valid) |->
      (rsp_o.red_out == '0 && rsp_o.green_out == '0 && rsp_o.blue_out == '0))
    else $error("non-read response with nonzero channels");

  // A response only appears when a request finishes.
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside of request completion");

  // The memory is only written while a request or the clearing pass runs.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
    else $error("memory written while no request is active");

endmodule

[hdl/vsbe_store.sv]
// Voxel memory: one write port, one read port, registered read data.
// No dependencies.
module vsbe_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/vsbe_blend.sv]
// Splat blend datapath: new = old + round((col - old) * w / 2^SS), per channel.
// The 2-part product is registered on cap_i; no package dependency.
module vsbe_blend #(
  parameter int unsigned CB = 16,
  parameter int unsigned WB = 33,
  parameter int unsigned SS = 32
) (
  input  logic            clk_i,
  input  logic            cap_i,
  input  logic [3*CB-1:0] old_i,
  input  logic [3*CB-1:0] col_i,
  input  logic [WB-1:0]   w_i,
  output logic [3*CB-1:0] new_o
);

  localparam int unsigned WL = (WB + 1) / 2;
  localparam int unsigned WH = WB - WL;
  localparam int unsigned PW = CB + 2 + WB;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (SS - 1);

  logic signed [WL:0] w_lo;
  logic signed [WH:0] w_hi;

  assign w_lo = $signed({1'b0, w_i[WL-1:0]});
  assign w_hi = $signed({1'b0, w_i[WB-1:WL]});

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [CB:0]      diff;
    logic signed [CB+WL+1:0] plo_q;
    logic signed [CB+WH+1:0] phi_q;
    logic [CB-1:0]           old_q;
    logic signed [PW-1:0]    sum;
    logic signed [PW-1:0]    step;
    logic signed [CB+1:0]    res;

    assign diff = $signed({1'b0, col_i[c*CB +: CB]}) - $signed({1'b0, old_i[c*CB +: CB]});

    always_ff @(posedge clk_i) begin
      if (cap_i) begin
        plo_q <= diff * w_lo;
        phi_q <= diff * w_hi;
        old_q <= old_i[c*CB +: CB];
      end
    end

    // Since w never exceeds 2^SS, the result stays between old and col.
    assign sum  = PW'(plo_q) + (PW'(phi_q) <<< WL);
    assign step = (sum + HALF) >>> SS;
    assign res  = (CB+2)'(step) + $signed({2'b00, old_q});
    assign new_o[c*CB +: CB] = res[CB-1:0];
  end

endmodule

[tb/sv/tb_voxel_splat_blend_engine_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the voxel splat and blend engine.
// Depends on vsbe_pkg, vsbe_req_if, vsbe_rsp_if and the engine top level.
module tb_voxel_splat_blend_engine_unit;
  import vsbe_pkg::*;

  localparam int unsigned SIDE = 8;
  localparam int unsigned VOXELS = SIDE * SIDE * SIDE;
  localparam int unsigned CHAN_MAX = 65535;
  localparam int unsigned SPLAT_SHIFT = 32;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [OP_BITS-1:0]     operation;
    logic [POS_BITS-1:0]    pos_x;
    logic [POS_BITS-1:0]    pos_y;
    logic [POS_BITS-1:0]    pos_z;
    logic [COLOR_BITS-1:0]  red_in;
    logic [COLOR_BITS-1:0]  green_in;
    logic [COLOR_BITS-1:0]  blue_in;
    logic [FACTOR_BITS-1:0] blend_factor;
  } request_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red_out;
    logic [OUT_BITS-1:0] green_out;
    logic [OUT_BITS-1:0] blue_out;
    logic                read_valid;
  } voxel_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vsbe_req_if req_if ();
  vsbe_rsp_if rsp_if ();

  voxel_splat_blend_engine_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the voxel cube, one entry per channel.
  logic [15:0] shadow_cube [VOXELS][3];

  request_t     pending_requests[$];
  voxel_reply_t expected_replies[$];

  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit stimulus_done = 1'b0;
  bit quiet_phase = 1'b0;
  bit hold_sender = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  // Colour scaling from 8 bits to the channel width, rounded to nearest.
  function automatic logic [15:0] scale_colour(logic [7:0] c);
    return 16'((32'(c) * CHAN_MAX + 127) / 255);
  endfunction

  function automatic logic [15:0] clamp_channel(longint unsigned v);
    return (v > CHAN_MAX) ? 16'(CHAN_MAX) : 16'(v);
  endfunction

  function automatic int unsigned voxel_index(int unsigned x, int unsigned y, int unsigned z);
    return (x * SIDE + y) * SIDE + z;
  endfunction

  // Applies one request to the shadow cube and returns the reply it gives.
  function automatic voxel_reply_t apply_request(request_t rq);
    voxel_reply_t reply;
    logic [15:0] colour [3];
    int unsigned ix, iy, iz, fx, fy, fz, alpha, nx, ny, nz, idx;
    longint unsigned wx [2], wy [2], wz [2], weight, den, acc;
    reply = '0;
    colour[0] = scale_colour(rq.red_in);
    colour[1] = scale_colour(rq.green_in);
    colour[2] = scale_colour(rq.blue_in);
    ix = rq.pos_x >> 8;
    iy = rq.pos_y >> 8;
    iz = rq.pos_z >> 8;
    case (rq.operation)
      OP_SPLAT: begin
        fx = rq.pos_x[7:0];
        fy = rq.pos_y[7:0];
        fz = rq.pos_z[7:0];
        // Opacity above one acts as full opacity.
        alpha = (rq.blend_factor > ALPHA_ONE) ? 256 : rq.blend_factor;
        wx[0] = 256 - fx; wx[1] = fx;
        wy[0] = 256 - fy; wy[1] = fy;
        wz[0] = 256 - fz; wz[1] = fz;
        den = 64'd1 << SPLAT_SHIFT;
        for (int n = 0; n < 8; n++) begin
          nx = ix + ((n >> 2) & 1);
          ny = iy + ((n >> 1) & 1);
          nz = iz + (n & 1);
          // Neighbors beyond the cube edge are dropped.
          if (nx < SIDE && ny < SIDE && nz < SIDE) begin
            weight = alpha * wx[(n >> 2) & 1] * wy[(n >> 1) & 1] * wz[n & 1];
            idx = voxel_index(nx, ny, nz);
            for (int c = 0; c < 3; c++) begin
              acc = longint'(shadow_cube[idx][c]) * (den - weight)
                    + longint'(colour[c]) * weight + (den >> 1);
              shadow_cube[idx][c] = clamp_channel(acc >> SPLAT_SHIFT);
            end
          end
        end
      end
      OP_SET: begin
        if (ix < SIDE && iy < SIDE && iz < SIDE)
          for (int c = 0; c < 3; c++) shadow_cube[voxel_index(ix, iy, iz)][c] = colour[c];
      end
      OP_FILL: begin
        for (int i = 0; i < VOXELS; i++)
          for (int c = 0; c < 3; c++) shadow_cube[i][c] = colour[c];
      end
      OP_DIM: begin
        // A factor above one brightens and saturates.
        for (int i = 0; i < VOXELS; i++)
          for (int c = 0; c < 3; c++)
            shadow_cube[i][c] = clamp_channel(
                (longint'(shadow_cube[i][c]) * rq.blend_factor + 128) >> 8);
      end
      OP_READ: begin
        if (ix < SIDE && iy < SIDE && iz < SIDE) begin
          idx = voxel_index(ix, iy, iz);
          reply.red_out = shadow_cube[idx][0];
          reply.green_out = shadow_cube[idx][1];
          reply.blue_out = shadow_cube[idx][2];
          reply.read_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic request_t make_request(logic [2:0] op, logic [10:0] x, logic [10:0] y,
                                            logic [10:0] z, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [8:0] f);
    request_t rq;
    rq.operation = op;
    rq.pos_x = x; rq.pos_y = y; rq.pos_z = z;
    rq.red_in = r; rq.green_in = g; rq.blue_in = b;
    rq.blend_factor = f;
    return rq;
  endfunction

  // Random position: anywhere in the 11-bit field, which always lies inside the cube.
  function automatic logic [10:0] random_position();
    if ($urandom_range(0, 9) == 0) return 11'($urandom);
    return 11'($urandom_range(0, 2047) & 11'h7ff) & ($urandom_range(0, 3) == 0 ? 11'h7ff : 11'h7ff);
  endfunction

  function automatic request_t random_request();
    logic [2:0] op;
    logic [8:0] factor;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    // Fill and dim are slow, so they are kept rare.
    if (pick < 45) op = OP_SPLAT;
    else if (pick < 62) op = OP_SET;
    else if (pick < 64) op = OP_FILL;
    else if (pick < 67) op = OP_DIM;
    else if (pick < 97) op = OP_READ;
    else op = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 9);
    if (pick == 0) factor = 9'($urandom);
    else if (op == OP_DIM) factor = 9'($urandom_range(200, 300));
    else factor = 9'($urandom_range(0, 256));
    return make_request(op, random_position(), random_position(), random_position(),
                        8'($urandom), 8'($urandom), 8'($urandom), factor);
  endfunction

  // Driver: presents the oldest pending request, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= '0;
      req_if.pos_x <= '0;
      req_if.pos_y <= '0;
      req_if.pos_z <= '0;
      req_if.red_in <= '0;
      req_if.green_in <= '0;
      req_if.blue_in <= '0;
      req_if.blend_factor <= '0;
      send_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_replies.push_back(apply_request(pending_requests.pop_front()));
      end
      if (req_if.valid && !req_if.ready) begin
        // The request on the bus stays until taken.
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(1, 8) - 1;
        req_if.valid <= 1'b0;
      end else if (hold_sender || pending_requests.size() == 0) begin
        req_if.valid <= 1'b0;
      end else begin
        req_if.valid <= 1'b1;
        {req_if.operation, req_if.pos_x, req_if.pos_y, req_if.pos_z, req_if.red_in,
         req_if.green_in, req_if.blue_in, req_if.blend_factor} <= pending_requests[0];
      end
    end
  end

  // Monitor: accepts replies with random stalls and checks each one.
  always @(posedge clk_i or negedge rst_ni) begin
    voxel_reply_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out, rsp_if.read_valid};
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected reply %h", got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reply mismatch: expected r=%h g=%h b=%h v=%b, got r=%h g=%h b=%h v=%b",
                       want.red_out, want.green_out, want.blue_out, want.read_valid,
                       got.red_out, got.green_out, got.blue_out, got.read_valid);
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(1, 8) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // The cube starts cleared, as the engine leaves it after reset.
    for (int i = 0; i < VOXELS; i++)
      for (int c = 0; c < 3; c++) shadow_cube[i][c] = '0;
    // Directed part: corners, every operation and each special case.
    pending_requests.push_back(make_request(OP_READ, 11'd0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_SET, 11'h000, 11'h000, 11'h000,
                                            8'd255, 8'd0, 8'd128, 9'd0));
    pending_requests.push_back(make_request(OP_READ, 11'h0ff, 11'h0ff, 11'h0ff,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_SET, 11'h7ff, 11'h7ff, 11'h7ff,
                                            8'd255, 8'd255, 8'd255, 9'h1ff));
    pending_requests.push_back(make_request(OP_READ, 11'h7ff, 11'h7ff, 11'h7ff,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_SET, 11'h800 - 1, 11'h000, 11'h100,
                                            8'd1, 8'd2, 8'd3, 9'd0));
    // Set voxel zero once more, then read it back.
    pending_requests.push_back(make_request(OP_SET, 11'h000, 11'h000, 11'h000,
                                            8'd9, 8'd9, 8'd9, 9'd0));
    pending_requests.push_back(make_request(OP_READ, 11'h000, 11'h000, 11'h000,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    // Splat at a corner, mid cell, at the upper edge and with opacity above one.
    pending_requests.push_back(make_request(OP_SPLAT, 11'h000, 11'h000, 11'h000,
                                            8'd255, 8'd255, 8'd255, 9'd256));
    pending_requests.push_back(make_request(OP_SPLAT, 11'h180, 11'h240, 11'h3c0,
                                            8'd200, 8'd50, 8'd10, 9'd128));
    pending_requests.push_back(make_request(OP_SPLAT, 11'h7ff, 11'h7ff, 11'h7ff,
                                            8'd17, 8'd255, 8'd0, 9'h1ff));
    pending_requests.push_back(make_request(OP_READ, 11'h700, 11'h700, 11'h700,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_READ, 11'h100, 11'h200, 11'h300,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_FILL, 11'd0, 11'd0, 11'd0,
                                            8'd255, 8'd255, 8'd255, 9'd0));
    // Dim above one saturates, a partial dim scales down, then dim to zero.
    pending_requests.push_back(make_request(OP_DIM, 11'd0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 9'h1ff));
    pending_requests.push_back(make_request(OP_READ, 11'h300, 11'h300, 11'h300,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_FILL, 11'h7ff, 11'h7ff, 11'h7ff,
                                            8'd100, 8'd7, 8'd255, 9'h1ff));
    pending_requests.push_back(make_request(OP_DIM, 11'd0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 9'd100));
    pending_requests.push_back(make_request(OP_READ, 11'h500, 11'h100, 11'h600,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_DIM, 11'd0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 9'd0));
    pending_requests.push_back(make_request(OP_READ, 11'h500, 11'h100, 11'h600,
                                            8'd0, 8'd0, 8'd0, 9'd0));
    // Unknown operation codes.
    for (int k = 5; k < 8; k++)
      pending_requests.push_back(make_request(3'(k), 11'h7ff, 11'h7ff, 11'h7ff,
                                              8'd255, 8'd255, 8'd255, 9'h1ff));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_requests.size() == 0);
    // Hold the sender until every reply has arrived, then continue.
    hold_sender = 1'b1;
    wait (expected_replies.size() == 0);
    @(posedge clk_i);
    for (int i = 0; i < 1200; i++) pending_requests.push_back(random_request());
    hold_sender = 1'b0;

    wait (pending_requests.size() < 150);
    quiet_phase = 1'b1;
    wait (pending_requests.size() == 0);
    wait (expected_replies.size() == 0);
    repeat (600) @(posedge clk_i);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
